/* rtl/vmie_pkg.sv */
// Package with the item types, opcodes, error codes and flag masks of the instruction execute block.
package vmie_pkg;

    localparam int IP_BITS = 32;

    typedef enum logic [3:0] {
        OP_LOAD = 4'd0,
        OP_INC  = 4'd1,
        OP_DEC  = 4'd2,
        OP_ADD  = 4'd3,
        OP_SUB  = 4'd4,
        OP_CMP  = 4'd5,
        OP_JE   = 4'd6,
        OP_JNE  = 4'd7,
        OP_JL   = 4'd8,
        OP_JG   = 4'd9,
        OP_JLE  = 4'd10,
        OP_JGE  = 4'd11,
        OP_PUSH = 4'd12,
        OP_POP  = 4'd13,
        OP_CALL = 4'd14,
        OP_RET  = 4'd15
    } opcode_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_POP      = 3'd1,
        ERR_RET      = 3'd2,
        ERR_JUMP     = 3'd3,
        ERR_OVERFLOW = 3'd4
    } err_t;

    localparam logic [3:0] FLAG_VALID = 4'h1;
    localparam logic [3:0] FLAG_EQ    = 4'h2;
    localparam logic [3:0] FLAG_LT    = 4'h4;
    localparam logic [3:0] FLAG_GT    = 4'h8;
    localparam logic [3:0] FLAG_LE    = 4'h6;
    localparam logic [3:0] FLAG_GE    = 4'hA;

    typedef struct packed {
        opcode_t            opcode;
        logic [2:0]         dest_reg;
        logic               a_is_reg;
        logic [31:0]        a_operand;
        logic               b_is_reg;
        logic [31:0]        b_operand;
        logic signed [31:0] jump_offset;
    } instr_t;

    typedef struct packed {
        logic        ok;
        err_t        error_code;
        logic [31:0] next_ip;
        logic [3:0]  flags_out;
        logic        reg_written;
        logic [31:0] written_value;
    } result_t;

    typedef struct packed {
        logic               tag;
        logic [IP_BITS-1:0] value;
    } stk_entry_t;

endpackage

/* rtl/vm_instruction_execute.sv */
// Top level of the instruction execute block: operand fetch, execute and result register.
//
// The block runs one decoded instruction of a small register machine per item.
// Items arrive on the instr channel (instr_valid, instr_stall, instr) and one result
// item per instruction leaves on the result channel (result_valid, result_stall,
// result). An item accepted at a clock edge has its source registers read at that
// edge, is executed from the operand registers and has its result registered in
// the result register as soon as that register is free.
// Throughput is one item per cycle unless the result side stalls; consecutive items
// see each other's register, flag and stack updates through forwarding on the
// register file read ports and on the stack read port, so no bubbles are inserted.
// The register file has two read ports, the stack memory one read port that always
// holds the entry just below the cached top of stack.
// When result_stall holds a finished result, the item in the execute stage waits
// and instr_stall rises; with the result register empty or draining, a new item is
// taken every cycle.
// Reset clears the registers, the instruction pointer, the compare flags and the
// stack depth at once; the stack memory itself needs no clearing pass.
module vm_instruction_execute
    import vmie_pkg::*;
#(
    parameter int NUM_REGS    = 8,
    parameter int STACK_DEPTH = 16,
    parameter int WORD_BITS   = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    instr_valid,
    output logic    instr_stall,
    input  instr_t  instr,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SP_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);

    // Pipeline control.
    logic in_valid_reg;
    logic in_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic advance;
    logic accept;

    // Register file.
    logic [WORD_BITS-1:0] rf_mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0]  rf_valid_reg;
    logic                 rf_we;
    logic [REG_IDX_W-1:0] rf_waddr;
    logic [WORD_BITS-1:0] rf_wdata;

    // Operand fetch.
    logic                 p1_dest;
    logic                 p1_is_reg;
    logic [31:0]          p1_index;
    logic                 p1_in_range;
    logic [REG_IDX_W-1:0] p1_addr;
    logic                 p1_hit;
    logic                 p1_use_mem;
    logic [WORD_BITS-1:0] p1_alt;
    logic                 p2_in_range;
    logic [REG_IDX_W-1:0] p2_addr;
    logic                 p2_hit;
    logic                 p2_use_mem;
    logic [WORD_BITS-1:0] p2_alt;

    instr_t               x_reg;
    logic [WORD_BITS-1:0] p1_mem_reg;
    logic [WORD_BITS-1:0] p2_mem_reg;
    logic [WORD_BITS-1:0] p1_alt_reg;
    logic [WORD_BITS-1:0] p2_alt_reg;
    logic                 p1_use_mem_reg;
    logic                 p2_use_mem_reg;

    // Architectural state.
    logic [IP_BITS-1:0] ip_reg;
    logic [IP_BITS-1:0] ip_next;
    logic [3:0]         flags_reg;
    logic [3:0]         flags_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;

    // Stack: the top entry is cached, the rest lives in memory.
    stk_entry_t         stk_mem_reg [STACK_DEPTH];
    stk_entry_t         top_reg;
    stk_entry_t         top_next;
    stk_entry_t         stk_rd_reg;
    stk_entry_t         stk_byp_val_reg;
    logic               stk_byp_reg;
    stk_entry_t         below;
    logic               stk_we;
    logic [SP_W-1:0]    stk_waddr;
    logic [SP_W-1:0]    stk_raddr;

    // Execute.
    logic [WORD_BITS-1:0] a;
    logic [WORD_BITS-1:0] b;
    err_t                 err;
    logic                 wr;
    logic [WORD_BITS-1:0] val;
    logic [IP_BITS-1:0]   exec_ip;
    logic [3:0]           exec_flags;
    logic                 taken;
    logic                 push_do;
    logic                 pop_do;
    stk_entry_t           push_entry;
    logic                 dest_ok;
    logic                 stk_full;
    logic                 stk_empty;
    result_t              res_reg;
    result_t              res_next;

    assign out_free    = !out_valid_reg || !result_stall;
    assign advance     = in_valid_reg && out_free;
    assign instr_stall = in_valid_reg && !out_free;
    assign accept      = instr_valid && !instr_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Inc, dec and push read the destination register on the first port.
    always_comb
    begin
        p1_dest     = (instr.opcode == OP_INC) || (instr.opcode == OP_DEC) ||
                      (instr.opcode == OP_PUSH);
        p1_is_reg   = p1_dest || instr.a_is_reg;
        p1_index    = p1_dest ? 32'(instr.dest_reg) : instr.a_operand;
        p1_in_range = p1_index < 32'(NUM_REGS);
        p1_addr     = REG_IDX_W'(p1_index);
        p1_hit      = rf_we && (rf_waddr == p1_addr);
        p1_use_mem  = p1_is_reg && p1_in_range && rf_valid_reg[p1_addr] && !p1_hit;
        if (!p1_is_reg)
        begin
            p1_alt = WORD_BITS'(instr.a_operand);
        end
        else if (p1_in_range && p1_hit)
        begin
            p1_alt = rf_wdata;
        end
        else
        begin
            p1_alt = '0;
        end

        p2_in_range = instr.b_operand < 32'(NUM_REGS);
        p2_addr     = REG_IDX_W'(instr.b_operand);
        p2_hit      = rf_we && (rf_waddr == p2_addr);
        p2_use_mem  = instr.b_is_reg && p2_in_range && rf_valid_reg[p2_addr] && !p2_hit;
        if (!instr.b_is_reg)
        begin
            p2_alt = WORD_BITS'(instr.b_operand);
        end
        else if (p2_in_range && p2_hit)
        begin
            p2_alt = rf_wdata;
        end
        else
        begin
            p2_alt = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem_reg[rf_waddr] <= rf_wdata;
        end
        if (accept)
        begin
            p1_mem_reg     <= rf_mem_reg[p1_addr];
            p2_mem_reg     <= rf_mem_reg[p2_addr];
            p1_alt_reg     <= p1_alt;
            p2_alt_reg     <= p2_alt;
            p1_use_mem_reg <= p1_use_mem;
            p2_use_mem_reg <= p2_use_mem;
            x_reg          <= instr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
        end
        else if (rf_we)
        begin
            rf_valid_reg[rf_waddr] <= 1'b1;
        end
    end

    assign a         = p1_use_mem_reg ? p1_mem_reg : p1_alt_reg;
    assign b         = p2_use_mem_reg ? p2_mem_reg : p2_alt_reg;
    assign below     = stk_byp_reg ? stk_byp_val_reg : stk_rd_reg;
    assign dest_ok   = 32'(x_reg.dest_reg) < 32'(NUM_REGS);
    assign stk_full  = depth_reg == DEPTH_W'(STACK_DEPTH);
    assign stk_empty = depth_reg == '0;

    always_comb
    begin
        err        = ERR_NONE;
        wr         = 1'b0;
        val        = '0;
        exec_ip    = ip_reg + IP_BITS'(1);
        exec_flags = flags_reg;
        taken      = 1'b0;
        push_do    = 1'b0;
        pop_do     = 1'b0;
        push_entry = '0;
        case (x_reg.opcode)
            OP_JE:   taken = (flags_reg & FLAG_EQ) != '0;
            OP_JNE:  taken = (flags_reg & FLAG_EQ) == '0;
            OP_JL:   taken = (flags_reg & FLAG_LT) != '0;
            OP_JG:   taken = (flags_reg & FLAG_GT) != '0;
            OP_JLE:  taken = (flags_reg & FLAG_LE) != '0;
            default: taken = (flags_reg & FLAG_GE) != '0;
        endcase
        unique case (x_reg.opcode)
            OP_LOAD:
            begin
                wr  = 1'b1;
                val = a;
            end
            OP_INC:
            begin
                wr  = 1'b1;
                val = a + WORD_BITS'(1);
            end
            OP_DEC:
            begin
                wr  = 1'b1;
                val = a - WORD_BITS'(1);
            end
            OP_ADD:
            begin
                wr  = 1'b1;
                val = a + b;
            end
            OP_SUB:
            begin
                wr  = 1'b1;
                val = a - b;
            end
            OP_CMP:
            begin
                exec_flags = {a > b, a < b, a == b, 1'b1};
            end
            OP_JE, OP_JNE, OP_JL, OP_JG, OP_JLE, OP_JGE:
            begin
                if ((flags_reg & FLAG_VALID) == '0)
                begin
                    err = ERR_JUMP;
                end
                else
                begin
                    if (taken)
                    begin
                        exec_ip = ip_reg + $unsigned(x_reg.jump_offset);
                    end
                    exec_flags = '0;
                end
            end
            OP_PUSH:
            begin
                if (stk_full)
                begin
                    err = ERR_OVERFLOW;
                end
                else
                begin
                    push_do          = 1'b1;
                    push_entry.tag   = 1'b0;
                    push_entry.value = IP_BITS'(a);
                end
            end
            OP_POP:
            begin
                if (stk_empty || top_reg.tag)
                begin
                    err = ERR_POP;
                end
                else
                begin
                    pop_do = 1'b1;
                    wr     = 1'b1;
                    val    = WORD_BITS'(top_reg.value);
                end
            end
            OP_CALL:
            begin
                if (stk_full)
                begin
                    err = ERR_OVERFLOW;
                end
                else
                begin
                    push_do          = 1'b1;
                    push_entry.tag   = 1'b1;
                    push_entry.value = ip_reg;
                    exec_ip          = ip_reg + $unsigned(x_reg.jump_offset);
                end
            end
            OP_RET:
            begin
                if (stk_empty || !top_reg.tag)
                begin
                    err = ERR_RET;
                end
                else
                begin
                    pop_do  = 1'b1;
                    exec_ip = top_reg.value + IP_BITS'(1);
                end
            end
        endcase
        if (err != ERR_NONE)
        begin
            wr      = 1'b0;
            val     = '0;
            exec_ip = ip_reg;
        end
        else if (wr && !dest_ok)
        begin
            wr  = 1'b0;
            val = '0;
        end
    end

    assign rf_we     = advance && wr;
    assign rf_waddr  = REG_IDX_W'(x_reg.dest_reg);
    assign rf_wdata  = val;
    assign stk_we    = advance && push_do && !stk_empty;
    assign stk_waddr = SP_W'(depth_reg - DEPTH_W'(1));
    assign stk_raddr = SP_W'(depth_next - DEPTH_W'(2));

    always_comb
    begin
        ip_next    = ip_reg;
        flags_next = flags_reg;
        depth_next = depth_reg;
        top_next   = top_reg;
        if (advance)
        begin
            ip_next    = exec_ip;
            flags_next = exec_flags;
            if (push_do)
            begin
                depth_next = depth_reg + DEPTH_W'(1);
                top_next   = push_entry;
            end
            else if (pop_do)
            begin
                depth_next = depth_reg - DEPTH_W'(1);
                top_next   = below;
            end
        end
        res_next.ok            = err == ERR_NONE;
        res_next.error_code    = err;
        res_next.next_ip       = exec_ip;
        res_next.flags_out     = exec_flags;
        res_next.reg_written   = wr;
        res_next.written_value = 32'(val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_reg      <= '0;
            flags_reg   <= '0;
            depth_reg   <= '0;
            stk_byp_reg <= 1'b0;
        end
        else
        begin
            ip_reg      <= ip_next;
            flags_reg   <= flags_next;
            depth_reg   <= depth_next;
            stk_byp_reg <= advance && push_do;
        end
    end

    // The read port always fetches the entry that sits below the next top of stack.
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem_reg[stk_waddr] <= top_reg;
        end
        stk_rd_reg      <= stk_mem_reg[stk_raddr];
        stk_byp_val_reg <= top_reg;
        top_reg         <= top_next;
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = res_reg;

endmodule

/* rtl/vmie_checker.sv */
// Port checker for the instruction execute block and its bind to the top level.
module vmie_checker
    import vmie_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    instr_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("A stalled result item changed or was dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.ok == (result.error_code == ERR_NONE)))
    else $error("The ok bit disagrees with the error code.");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.ok |-> !result.reg_written && result.written_value == '0)
    else $error("A failed instruction reported a register write.");

    assert property (@(posedge clk) disable iff (!rst_n)
        instr_stall |-> result_valid && result_stall)
    else $error("The input stalled while the result side was free.");

endmodule

bind vm_instruction_execute vmie_checker u_vmie_checker (.*);
